FILE: hw/rtl/menu_key_repeat_debounce_unit_defines.svh
// ----------------------------------------------------------------------------
// Menu key qualifier assertion macros
// Concurrent check wrappers shared by the files that carry assertions.
// ----------------------------------------------------------------------------
`ifndef MENU_KEY_REPEAT_DEBOUNCE_UNIT_DEFINES_SVH
`define MENU_KEY_REPEAT_DEBOUNCE_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Check an implication on every clock edge outside reset.
`define MKRD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mkrd: implication check failed");

// Check a next-cycle implication on every clock edge, reset included.
`define MKRD_ASSERT_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("mkrd: next-cycle check failed");

`else

`define MKRD_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define MKRD_ASSERT_NEXT(label, clk, ante, cons)

`endif

`endif

FILE: hw/rtl/mkrd_pkg.sv
// ----------------------------------------------------------------------------
// Menu key qualifier package
// Shared widths, codes, register defaults and bundle types.
// ----------------------------------------------------------------------------
package mkrd_pkg;

   localparam int TIME_WIDTH_DEFAULT = 32;
   localparam int BTN_WIDTH          = 7;
   localparam int DIR_WIDTH          = 4;
   localparam int ACT_WIDTH          = 3;
   localparam int CSR_WIDTH          = 16;
   localparam int CSR_INDEX_WIDTH    = 2;
   localparam int NOW_WIDTH          = 32;
   localparam int KIND_WIDTH         = 2;

   // Item kinds
   localparam logic [KIND_WIDTH-1:0] KIND_POLL     = 2'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_INJECT   = 2'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_SUPPRESS = 2'd2;

   // Register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_REPEAT_DELAY  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_REPEAT_PERIOD = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEBOUNCE      = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RELEASE_SETTLE = 2'd3;

   // Register reset values
   localparam logic [CSR_WIDTH-1:0] RESET_REPEAT_DELAY   = 16'd400;
   localparam logic [CSR_WIDTH-1:0] RESET_REPEAT_PERIOD  = 16'd100;
   localparam logic [CSR_WIDTH-1:0] RESET_DEBOUNCE       = 16'd50;
   localparam logic [CSR_WIDTH-1:0] RESET_RELEASE_SETTLE = 16'd100;

   typedef struct packed {
      logic [CSR_WIDTH-1:0] repeat_delay;
      logic [CSR_WIDTH-1:0] repeat_period;
      logic [CSR_WIDTH-1:0] debounce;
      logic [CSR_WIDTH-1:0] release_settle;
   } cfg_type;

   typedef struct packed {
      logic [BTN_WIDTH-1:0] seen;
      logic [BTN_WIDTH-1:0] pulse;
   } result_type;

endpackage

FILE: hw/rtl/mkrd_csr.sv
// ----------------------------------------------------------------------------
// Menu key qualifier configuration registers
// Four timing registers written through a plain write port.
// ----------------------------------------------------------------------------
module mkrd_csr (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write_enable,
   input  logic [mkrd_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [mkrd_pkg::CSR_WIDTH-1:0]         csr_write_data,
   output mkrd_pkg::cfg_type                      cfg
);
   import mkrd_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_REPEAT_DELAY:   cfg_in.repeat_delay   = csr_write_data;
            CSR_REPEAT_PERIOD:  cfg_in.repeat_period  = csr_write_data;
            CSR_DEBOUNCE:       cfg_in.debounce       = csr_write_data;
            CSR_RELEASE_SETTLE: cfg_in.release_settle = csr_write_data;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.repeat_delay   <= RESET_REPEAT_DELAY;
         cfg_ff.repeat_period  <= RESET_REPEAT_PERIOD;
         cfg_ff.debounce       <= RESET_DEBOUNCE;
         cfg_ff.release_settle <= RESET_RELEASE_SETTLE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: hw/rtl/mkrd_eval.sv
// ----------------------------------------------------------------------------
// Menu key qualifier evaluation
// Key history state and the single-pass next-state and result logic.
// ----------------------------------------------------------------------------
module mkrd_eval #(
   parameter int TIME_WIDTH = mkrd_pkg::TIME_WIDTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  mkrd_pkg::cfg_type                  cfg,
   input  logic                               fire,
   input  logic [mkrd_pkg::KIND_WIDTH-1:0]    kind,
   input  logic [mkrd_pkg::NOW_WIDTH-1:0]     now_ms,
   input  logic [mkrd_pkg::BTN_WIDTH-1:0]     pad_buttons,
   input  logic                               pad_connected,
   input  logic [mkrd_pkg::BTN_WIDTH-1:0]     inject_buttons,
   input  logic [mkrd_pkg::CSR_WIDTH-1:0]     suppress_ms,
   output mkrd_pkg::result_type               result
);
   import mkrd_pkg::*;

   logic [BTN_WIDTH-1:0]  prev_held_ff,   prev_held_in;
   logic [TIME_WIDTH-1:0] rpt_deadline_ff, rpt_deadline_in;
   logic [TIME_WIDTH-1:0] last_action_ff, last_action_in;
   logic [ACT_WIDTH-1:0]  deferred_ff,    deferred_in;
   logic [BTN_WIDTH-1:0]  queued_ff,      queued_in;
   logic [TIME_WIDTH-1:0] supp_until_ff,  supp_until_in;
   logic                  wait_rel_ff,    wait_rel_in;
   logic [TIME_WIDTH-1:0] rel_since_ff,   rel_since_in;

   logic [TIME_WIDTH-1:0] now_t;
   logic [BTN_WIDTH-1:0]  held;
   logic [BTN_WIDTH-1:0]  inj;
   logic [BTN_WIDTH-1:0]  pressed;
   logic [BTN_WIDTH-1:0]  act;
   logic [TIME_WIDTH-1:0] supp_diff;
   logic [TIME_WIDTH-1:0] settle_diff;
   logic [TIME_WIDTH-1:0] action_diff;
   logic [TIME_WIDTH-1:0] now_plus_delay;
   logic [TIME_WIDTH-1:0] now_plus_period;
   logic [TIME_WIDTH-1:0] deadline_armed;
   logic [TIME_WIDTH-1:0] deadline_diff;
   logic                  suppressed;
   logic                  can_act;
   logic                  rpt;
   logic [DIR_WIDTH-1:0]  dirs;
   logic [ACT_WIDTH-1:0]  acts;

   // Time arithmetic
   assign now_t           = TIME_WIDTH'(now_ms);
   assign held            = pad_connected ? pad_buttons : '0;
   assign inj             = queued_ff;
   assign supp_diff       = now_t - supp_until_ff;
   assign settle_diff     = now_t - rel_since_ff;
   assign action_diff     = now_t - last_action_ff;
   assign now_plus_delay  = now_t + TIME_WIDTH'(cfg.repeat_delay);
   assign now_plus_period = now_t + TIME_WIDTH'(cfg.repeat_period);
   assign pressed         = held & ~prev_held_ff;
   assign act             = pressed | inj;
   assign deadline_armed  = (pressed != '0) ? now_plus_delay : rpt_deadline_ff;
   assign deadline_diff   = now_t - deadline_armed;
   assign can_act         = action_diff >= TIME_WIDTH'(cfg.debounce);
   assign rpt             = can_act && (held[DIR_WIDTH-1:0] != '0) &&
                            !deadline_diff[TIME_WIDTH-1];
   assign dirs            = act[DIR_WIDTH-1:0] |
                            (rpt ? held[DIR_WIDTH-1:0] : '0);
   assign acts            = act[BTN_WIDTH-1:DIR_WIDTH] | deferred_ff;

   always_comb begin
      prev_held_in    = prev_held_ff;
      rpt_deadline_in = rpt_deadline_ff;
      last_action_in  = last_action_ff;
      deferred_in     = deferred_ff;
      queued_in       = queued_ff;
      supp_until_in   = supp_until_ff;
      wait_rel_in     = wait_rel_ff;
      rel_since_in    = rel_since_ff;
      suppressed      = 1'b0;
      result          = '0;

      // Suppression check: deadline first, then the all-released settle time
      if ((supp_until_ff != '0) && supp_diff[TIME_WIDTH-1]) begin
         suppressed = 1'b1;
      end else begin
         supp_until_in = '0;
         if (wait_rel_ff) begin
            if (held != '0) begin
               rel_since_in = '0;
               suppressed   = 1'b1;
            end else if (rel_since_ff == '0) begin
               rel_since_in = now_t;
               suppressed   = 1'b1;
            end else if (settle_diff < TIME_WIDTH'(cfg.release_settle)) begin
               suppressed   = 1'b1;
            end else begin
               wait_rel_in  = 1'b0;
               rel_since_in = '0;
            end
         end
      end

      if (fire) begin
         case (kind)
            KIND_INJECT: begin
               supp_until_in = supp_until_ff;
               wait_rel_in   = wait_rel_ff;
               rel_since_in  = rel_since_ff;
               queued_in     = queued_ff | inject_buttons;
            end
            KIND_SUPPRESS: begin
               supp_until_in = now_t + TIME_WIDTH'(suppress_ms);
               wait_rel_in   = 1'b1;
               rel_since_in  = '0;
               deferred_in   = '0;
            end
            KIND_POLL: begin
               queued_in = '0;
               if (suppressed) begin
                  // Reload the history so nothing fires on release
                  prev_held_in    = held;
                  rpt_deadline_in = now_plus_delay;
                  last_action_in  = now_t;
                  deferred_in     = '0;
                  result.seen     = inj;
               end else begin
                  result.seen     = held | inj;
                  prev_held_in    = held;
                  rpt_deadline_in = rpt ? now_plus_period : deadline_armed;
                  if (!can_act) begin
                     // Hold confirm, back and start edges until the window ends
                     deferred_in = deferred_ff | act[BTN_WIDTH-1:DIR_WIDTH];
                  end else begin
                     deferred_in  = '0;
                     result.pulse = {acts, dirs};
                     if ((dirs != '0) || (acts != '0)) begin
                        last_action_in = now_t;
                     end
                  end
               end
            end
            default: begin
               supp_until_in = supp_until_ff;
               wait_rel_in   = wait_rel_ff;
               rel_since_in  = rel_since_ff;
            end
         endcase
      end else begin
         supp_until_in = supp_until_ff;
         wait_rel_in   = wait_rel_ff;
         rel_since_in  = rel_since_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_held_ff    <= '0;
         rpt_deadline_ff <= '0;
         last_action_ff  <= '0;
         deferred_ff     <= '0;
         queued_ff       <= '0;
         supp_until_ff   <= '0;
         wait_rel_ff     <= 1'b0;
         rel_since_ff    <= '0;
      end else begin
         prev_held_ff    <= prev_held_in;
         rpt_deadline_ff <= rpt_deadline_in;
         last_action_ff  <= last_action_in;
         deferred_ff     <= deferred_in;
         queued_ff       <= queued_in;
         supp_until_ff   <= supp_until_in;
         wait_rel_ff     <= wait_rel_in;
         rel_since_ff    <= rel_since_in;
      end
   end

endmodule

FILE: hw/rtl/menu_key_repeat_debounce_unit.sv
// ----------------------------------------------------------------------------
// Menu key repeat and debounce unit
// Qualifies seven menu buttons into press pulses with auto-repeat,
// debounce with deferred actions, injected presses and suppression.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake          | carries
//   --------+-----------+--------------------+----------------------------------
//   req_    | in        | req_valid/req_stall| one poll, inject or suppress beat
//   rsp_    | out       | rsp_valid/rsp_stall| one result beat per poll
//   csr_    | in        | csr_write_enable   | timing register write, no wait
//
// One beat is taken every clock while req_stall is low: a request beat is
// registered, evaluated in one pass against the key history, and a poll lands
// in the result register once that register is free.
// Inject and suppress beats update the history and never wait on rsp_stall.
// A stalled result holds the result register; a poll behind it then holds
// the request register and raises req_stall in the same cycle.
// Reset clears the key history and loads the register defaults (400, 100,
// 50 and 100 ms).
// ----------------------------------------------------------------------------
`include "menu_key_repeat_debounce_unit_defines.svh"

module menu_key_repeat_debounce_unit #(
   parameter int TIME_WIDTH = mkrd_pkg::TIME_WIDTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [mkrd_pkg::KIND_WIDTH-1:0]      req_kind,
   input  logic [mkrd_pkg::NOW_WIDTH-1:0]       req_now_ms,
   input  logic [mkrd_pkg::BTN_WIDTH-1:0]       req_pad_buttons,
   input  logic                                 req_pad_connected,
   input  logic [mkrd_pkg::BTN_WIDTH-1:0]       req_inject_buttons,
   input  logic [mkrd_pkg::CSR_WIDTH-1:0]       req_suppress_ms,
   // result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [mkrd_pkg::BTN_WIDTH-1:0]       rsp_seen_buttons,
   output logic                                 rsp_up_pulse,
   output logic                                 rsp_down_pulse,
   output logic                                 rsp_left_pulse,
   output logic                                 rsp_right_pulse,
   output logic                                 rsp_confirm_pulse,
   output logic                                 rsp_back_pulse,
   output logic                                 rsp_start_pulse,
   // configuration port
   input  logic                                 csr_write_enable,
   input  logic [mkrd_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [mkrd_pkg::CSR_WIDTH-1:0]       csr_write_data
);
   import mkrd_pkg::*;

   cfg_type    cfg;
   result_type eval_result;

   // Request register
   logic                   s1_valid_ff, s1_valid_in;
   logic [KIND_WIDTH-1:0]  s1_kind_ff;
   logic [NOW_WIDTH-1:0]   s1_now_ff;
   logic [BTN_WIDTH-1:0]   s1_buttons_ff;
   logic                   s1_connected_ff;
   logic [BTN_WIDTH-1:0]   s1_inject_ff;
   logic [CSR_WIDTH-1:0]   s1_suppress_ff;

   // Result register
   logic                   out_valid_ff, out_valid_in;
   result_type             out_result_ff;

   logic req_fire;
   logic out_free;
   logic s1_is_poll;
   logic s1_go;

   mkrd_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   // Advance the request register whenever its beat can leave: a non-poll
   // beat always can, a poll only when the result register is free
   assign out_free   = !out_valid_ff || !rsp_stall;
   assign s1_is_poll = (s1_kind_ff == KIND_POLL);
   assign s1_go      = s1_valid_ff && (!s1_is_poll || out_free);
   assign req_stall  = s1_valid_ff && !s1_go;
   assign req_fire   = req_valid && !req_stall;

   assign s1_valid_in  = req_fire || (s1_valid_ff && !s1_go);
   assign out_valid_in = (s1_go && s1_is_poll) || (out_valid_ff && rsp_stall);

   mkrd_eval #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_eval (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .fire           (s1_go),
      .kind           (s1_kind_ff),
      .now_ms         (s1_now_ff),
      .pad_buttons    (s1_buttons_ff),
      .pad_connected  (s1_connected_ff),
      .inject_buttons (s1_inject_ff),
      .suppress_ms    (s1_suppress_ff),
      .result         (eval_result)
   );

   // Control flops
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload flops: load on accept, hold otherwise
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_kind_ff      <= req_kind;
         s1_now_ff       <= req_now_ms;
         s1_buttons_ff   <= req_pad_buttons;
         s1_connected_ff <= req_pad_connected;
         s1_inject_ff    <= req_inject_buttons;
         s1_suppress_ff  <= req_suppress_ms;
      end
      if (s1_go && s1_is_poll) begin
         out_result_ff <= eval_result;
      end
   end

   // Drive the result ports from the result register
   assign rsp_valid         = out_valid_ff;
   assign rsp_seen_buttons  = out_result_ff.seen;
   assign rsp_up_pulse      = out_result_ff.pulse[0];
   assign rsp_down_pulse    = out_result_ff.pulse[1];
   assign rsp_left_pulse    = out_result_ff.pulse[2];
   assign rsp_right_pulse   = out_result_ff.pulse[3];
   assign rsp_confirm_pulse = out_result_ff.pulse[4];
   assign rsp_back_pulse    = out_result_ff.pulse[5];
   assign rsp_start_pulse   = out_result_ff.pulse[6];

   // Checks
   // Inject and suppress beats never back up the request side
   `MKRD_ASSERT_IMPLY(a_nonpoll_no_stall, clock, reset,
      s1_valid_ff && !s1_is_poll, !req_stall)
   // Stall only with a beat parked in the request register
   `MKRD_ASSERT_IMPLY(a_stall_needs_beat, clock, reset, req_stall, s1_valid_ff)
   // A direction pulse always comes from a seen (held or injected) button
   `MKRD_ASSERT_IMPLY(a_dir_pulse_seen, clock, reset, rsp_valid,
      (out_result_ff.pulse[DIR_WIDTH-1:0] & ~out_result_ff.seen[DIR_WIDTH-1:0]) == '0)
   // Reset empties both registers
   `MKRD_ASSERT_NEXT(a_reset_empty, clock, reset, !rsp_valid && !s1_valid_ff)

endmodule
